// File: design/pgss_pkg.sv
// pgss_pkg: shared constants and codes for the pitch/gate step sequencer
// no dependencies; imported by every module of the block

package pgss_pkg;

    // configuration register indexes
    typedef logic [2:0] t_reg_index;
    localparam t_reg_index REG_STEP_COUNT      = 3'd0;
    localparam t_reg_index REG_STEP_DIRECTION  = 3'd1;
    localparam t_reg_index REG_PHASE_INCREMENT = 3'd2;
    localparam t_reg_index REG_GATE_THRESHOLD  = 3'd3;
    localparam t_reg_index REG_RAMP_INCREMENT  = 3'd4;
    localparam t_reg_index REG_GATE_MASK       = 3'd5;
    localparam t_reg_index REG_PITCH_BANK_LOW  = 3'd6;
    localparam t_reg_index REG_PITCH_BANK_HIGH = 3'd7;

    localparam int CFG_DATA_W = 40;

    // advance modes
    typedef logic [1:0] t_direction;
    localparam t_direction DIR_FORWARD  = 2'd0;
    localparam t_direction DIR_BACKWARD = 2'd1;
    localparam t_direction DIR_PENDULUM = 2'd2;
    localparam t_direction DIR_RANDOM   = 2'd3;

    // random step generator
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // gate level
    localparam logic [15:0] GATE_FULL = 16'hFFFF;
    localparam logic [15:0] GATE_SHUT = 16'h0000;

endpackage

// File: design/pitch_gate_step_sequencer_top.sv
// pitch_gate_step_sequencer_top: step sequencer with pitch and ramped gate per sample
// depends on pgss_pkg, pgss_step_next and pgss_gate_ramp
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+--------------------------------------
//   in      | sink      | i_in_valid / o_in_stall     | i_clock_level, i_clock_patched,
//           |           |                             | i_reset_level
//   out     | source    | o_out_valid / i_out_stall   | o_pitch_semitones, o_gate_level,
//           |           |                             | o_current_step
//   cfg     | sink      | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the out channel is not stalled; an item is held in
// the input register, then the sequencer state and the result register update together when it drains
// an accepted item passes the input register and then the result register, which drives
// the out channel
// reset (i_rst_n low, synchronous) empties both registers and loads the state reset values
// a stalled result holds the result register; the input register still takes one more
// item, and o_in_stall rises only when that register is full and cannot drain

module pitch_gate_step_sequencer_top
    import pgss_pkg::*;
#(
    parameter int MAX_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration writes
    input  logic                  i_cfg_we,
    input  t_reg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // sample items in
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_clock_level,
    input  logic                  i_clock_patched,
    input  logic                  i_reset_level,

    // result items out
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [4:0]     o_pitch_semitones,
    output logic [15:0]           o_gate_level,
    output logic [3:0]            o_current_step
);

    localparam int PW = $clog2(MAX_STEPS);
    localparam int CW = $clog2(MAX_STEPS + 1);

    // configuration registers
    logic [4:0]  r_step_count;
    t_direction  r_step_direction;
    logic [31:0] r_phase_increment;
    logic [31:0] r_gate_threshold;
    logic [15:0] r_ramp_increment;
    logic [15:0] r_gate_mask;
    logic [39:0] r_pitch_bank_low;
    logic [39:0] r_pitch_bank_high;

    // input register
    logic        r_in_valid;
    logic        r_clock_level;
    logic        r_clock_patched;
    logic        r_reset_level;

    // sequencer state
    logic [PW-1:0] r_pos;
    logic          r_rising;
    logic [31:0]   r_phase;
    logic          r_prev_reset;
    logic          r_prev_clock;
    logic [15:0]   r_gate;
    logic [15:0]   r_lfsr;

    // result register
    logic          r_out_valid;
    logic [4:0]    r_pitch;
    logic [15:0]   r_level;
    logic [3:0]    r_step;

    // next-state values
    logic [PW-1:0] n_pos;
    logic          n_rising;
    logic [31:0]   n_phase;
    logic          n_prev_clock;
    logic [15:0]   n_gate;
    logic [15:0]   n_lfsr;
    logic [4:0]    n_pitch;

    logic          fire;
    logic          accept;
    logic [31:0]   count_wide;
    logic [CW-1:0] count;
    logic          reset_edge;
    logic [PW-1:0] pos_after_reset;
    logic          rising_after_reset;
    logic [31:0]   phase_after_reset;
    logic [PW-1:0] pos_checked;
    logic [32:0]   phase_sum;
    logic          advance;
    logic          window;
    logic [31:0]   pos_wide;
    logic          step_open;
    logic [5:0]    bit_base;

    // the input register drains into the result register when that is empty or taken this cycle
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    // effective step count clamped to 1..MAX_STEPS
    assign count_wide = 32'(r_step_count);
    always_comb begin
        if (count_wide == 32'd0) begin
            count = CW'(1);
        end else if (count_wide > 32'(MAX_STEPS)) begin
            count = CW'(MAX_STEPS);
        end else begin
            count = CW'(count_wide);
        end
    end

    // rising reset input sends the sequence home
    assign reset_edge         = r_reset_level && !r_prev_reset;
    assign pos_after_reset    = reset_edge ? '0 : r_pos;
    assign rising_after_reset = reset_edge ? 1'b1 : r_rising;
    assign phase_after_reset  = reset_edge ? 32'd0 : r_phase;

    // a position left outside a shrunken sequence restarts at step 0
    assign pos_checked = (CW'(pos_after_reset) >= count) ? '0 : pos_after_reset;

    // clock source: external edge, or carry out of the phase accumulator
    assign phase_sum = {1'b0, phase_after_reset} + {1'b0, r_phase_increment};
    always_comb begin
        if (r_clock_patched) begin
            advance      = r_clock_level && !r_prev_clock;
            window       = r_clock_level;
            n_phase      = phase_after_reset;
            n_prev_clock = r_clock_level;
        end else begin
            advance      = phase_sum[32];
            window       = phase_sum[31:0] < r_gate_threshold;
            n_phase      = phase_sum[31:0];
            n_prev_clock = r_prev_clock;
        end
    end

    pgss_step_next #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step_next (
        .i_pos     (pos_checked),
        .i_count   (count),
        .i_rising  (rising_after_reset),
        .i_lfsr    (r_lfsr),
        .i_dir     (r_step_direction),
        .i_advance (advance),
        .o_pos     (n_pos),
        .o_rising  (n_rising),
        .o_lfsr    (n_lfsr)
    );

    // steps past sixteen have no pitch and a closed gate
    assign pos_wide  = 32'(n_pos);
    assign step_open = (pos_wide < 32'd16) && r_gate_mask[pos_wide[3:0]];
    assign bit_base  = 6'(pos_wide[2:0]) * 6'd5;

    always_comb begin
        if (pos_wide >= 32'd16) begin
            n_pitch = 5'd0;
        end else if (pos_wide[3]) begin
            n_pitch = r_pitch_bank_high[bit_base +: 5];
        end else begin
            n_pitch = r_pitch_bank_low[bit_base +: 5];
        end
    end

    pgss_gate_ramp u_gate_ramp (
        .i_window (window),
        .i_open   (step_open),
        .i_level  (r_gate),
        .i_ramp   (r_ramp_increment),
        .o_level  (n_gate)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count      <= 5'd16;
            r_step_direction  <= DIR_FORWARD;
            r_phase_increment <= 32'd0;
            r_gate_threshold  <= 32'h8000_0000;
            r_ramp_increment  <= 16'd1365;
            r_gate_mask       <= 16'hFFFF;
            r_pitch_bank_low  <= 40'd0;
            r_pitch_bank_high <= 40'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEP_COUNT:      r_step_count      <= i_cfg_data[4:0];
                REG_STEP_DIRECTION:  r_step_direction  <= i_cfg_data[1:0];
                REG_PHASE_INCREMENT: r_phase_increment <= i_cfg_data[31:0];
                REG_GATE_THRESHOLD:  r_gate_threshold  <= i_cfg_data[31:0];
                REG_RAMP_INCREMENT:  r_ramp_increment  <= i_cfg_data[15:0];
                REG_GATE_MASK:       r_gate_mask       <= i_cfg_data[15:0];
                REG_PITCH_BANK_LOW:  r_pitch_bank_low  <= i_cfg_data[39:0];
                REG_PITCH_BANK_HIGH: r_pitch_bank_high <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_clock_level   <= i_clock_level;
            r_clock_patched <= i_clock_patched;
            r_reset_level   <= i_reset_level;
        end
    end

    // sequencer state moves only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_rising     <= 1'b1;
            r_phase      <= 32'd0;
            r_prev_reset <= 1'b0;
            r_prev_clock <= 1'b0;
            r_gate       <= 16'd0;
            r_lfsr       <= LFSR_SEED;
        end else if (fire) begin
            r_pos        <= n_pos;
            r_rising     <= n_rising;
            r_phase      <= n_phase;
            r_prev_reset <= r_reset_level;
            r_prev_clock <= n_prev_clock;
            r_gate       <= n_gate;
            r_lfsr       <= n_lfsr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pitch <= n_pitch;
            r_level <= n_gate;
            r_step  <= pos_wide[3:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pitch_semitones = signed'(r_pitch);
    assign o_gate_level      = r_level;
    assign o_current_step    = r_step;

    // checks on the sequencer's own logic

    // the random register must never lock up at zero
    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'h0000)
        else $error("random step register reached zero");

    // a processed item always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item did not reach the result register");

    // sequencer state only moves with a processed item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_pos) && $stable(r_phase) && $stable(r_gate)
                   && $stable(r_lfsr)))
        else $error("sequencer state changed without an item");

endmodule

// File: design/pgss_step_next.sv
// pgss_step_next: next step position, pendulum direction and random register
// depends on pgss_pkg (direction codes, lfsr constants)

module pgss_step_next
    import pgss_pkg::*;
#(
    parameter int MAX_STEPS = 16
) (
    input  logic [$clog2(MAX_STEPS)-1:0]   i_pos,
    input  logic [$clog2(MAX_STEPS+1)-1:0] i_count,
    input  logic                           i_rising,
    input  logic [15:0]                    i_lfsr,
    input  t_direction                     i_dir,
    input  logic                           i_advance,
    output logic [$clog2(MAX_STEPS)-1:0]   o_pos,
    output logic                           o_rising,
    output logic [15:0]                    o_lfsr
);

    localparam int PW = $clog2(MAX_STEPS);
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int MW = 16 + CW;

    logic [CW-1:0] pos_c;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] pos_dec;
    logic [CW-1:0] last;
    logic [15:0]   lfsr_shift;
    logic [15:0]   lfsr_new;
    logic [MW-1:0] scaled;

    assign pos_c   = CW'(i_pos);
    assign pos_inc = pos_c + CW'(1);
    assign pos_dec = pos_c - CW'(1);
    assign last    = i_count - CW'(1);

    // galois shift, never left at zero
    assign lfsr_shift = i_lfsr[0] ? ((i_lfsr >> 1) ^ LFSR_TAPS) : (i_lfsr >> 1);
    assign lfsr_new   = (lfsr_shift == 16'h0000) ? LFSR_SEED : lfsr_shift;
    assign scaled     = MW'(lfsr_new) * MW'(i_count);

    always_comb begin
        o_pos    = i_pos;
        o_rising = i_rising;
        o_lfsr   = i_lfsr;
        if (i_advance) begin
            case (i_dir)
                DIR_FORWARD: begin
                    o_pos = (pos_inc == i_count) ? '0 : PW'(pos_inc);
                end
                DIR_BACKWARD: begin
                    o_pos = (pos_c == '0) ? PW'(last) : PW'(pos_dec);
                end
                DIR_PENDULUM: begin
                    if (i_count < CW'(2)) begin
                        o_pos = '0;
                    end else if (i_rising) begin
                        if (pos_inc >= last) begin
                            o_pos    = PW'(last);
                            o_rising = 1'b0;
                        end else begin
                            o_pos = PW'(pos_inc);
                        end
                    end else begin
                        if (pos_c <= CW'(1)) begin
                            o_pos    = '0;
                            o_rising = 1'b1;
                        end else begin
                            o_pos = PW'(pos_dec);
                        end
                    end
                end
                default: begin
                    o_lfsr = lfsr_new;
                    o_pos  = scaled[16 +: PW];
                end
            endcase
        end
    end

endmodule

// File: design/pgss_gate_ramp.sv
// pgss_gate_ramp: moves the gate level toward open or shut, saturating at target
// depends on pgss_pkg (gate level constants)

module pgss_gate_ramp
    import pgss_pkg::*;
(
    input  logic        i_window,
    input  logic        i_open,
    input  logic [15:0] i_level,
    input  logic [15:0] i_ramp,
    output logic [15:0] o_level
);

    logic [15:0] target;
    logic [16:0] rise;
    logic [15:0] drop;

    assign target = (i_window && i_open) ? GATE_FULL : GATE_SHUT;
    assign rise   = {1'b0, i_level} + {1'b0, i_ramp};
    assign drop   = i_level - target;

    always_comb begin
        if (i_level < target) begin
            o_level = (rise > {1'b0, target}) ? target : rise[15:0];
        end else if (i_level > target) begin
            o_level = (drop > i_ramp) ? (i_level - i_ramp) : target;
        end else begin
            o_level = i_level;
        end
    end

endmodule

// File: sim/tb_pitch_gate_step_sequencer_top.sv
// tb_pitch_gate_step_sequencer_top: self-checking bench for the pitch/gate step sequencer
// depends on pgss_pkg and pitch_gate_step_sequencer_top; a built-in sequencer model
// predicts each result, which is checked field by field against the out channel

module tb_pitch_gate_step_sequencer_top;
    import pgss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STEPS = 16;

    // one full register set, as the model and the write sequence see it
    typedef struct {
        logic [4:0]  step_count;
        t_direction  direction;
        logic [31:0] phase_inc;
        logic [31:0] gate_thr;
        logic [15:0] ramp_inc;
        logic [15:0] gate_mask;
        logic [39:0] pitch_lo;
        logic [39:0] pitch_hi;
    } t_seq_cfg;

    typedef struct packed {
        logic signed [4:0] pitch;
        logic [15:0]       gate;
        logic [3:0]        step;
    } t_sample_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_reg_index            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_clock_level;
    logic                  i_clock_patched;
    logic                  i_reset_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [4:0]     o_pitch_semitones;
    logic [15:0]           o_gate_level;
    logic [3:0]            o_current_step;

    // model copy of the registers and the sequencer state
    t_seq_cfg    active_cfg;
    int unsigned seq_pos;
    logic        pend_up;
    logic [31:0] acc_phase;
    logic        last_rst_lvl;
    logic        last_clk_lvl;
    int unsigned gate_amp;
    logic [15:0] lfsr_state;

    t_sample_result expected_results[$];
    int             mismatch_count = 0;

    // idling controls for the sender and the receiver
    bit in_gaps_on   = 1'b1;
    bit out_gaps_on  = 1'b1;
    bit hold_request = 1'b0;
    int hold_cycles  = 0;

    pitch_gate_step_sequencer_top #(
        .MAX_STEPS (NUM_STEPS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_clock_level     (i_clock_level),
        .i_clock_patched   (i_clock_patched),
        .i_reset_level     (i_reset_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pitch_semitones (o_pitch_semitones),
        .o_gate_level      (o_gate_level),
        .o_current_step    (o_current_step)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------

    function automatic void reset_model();
        active_cfg = '{step_count: 5'd16, direction: DIR_FORWARD, phase_inc: 32'd0,
                       gate_thr: 32'h8000_0000, ramp_inc: 16'd1365, gate_mask: 16'hFFFF,
                       pitch_lo: 40'd0, pitch_hi: 40'd0};
        seq_pos      = 0;
        pend_up      = 1'b1;
        acc_phase    = '0;
        last_rst_lvl = 1'b0;
        last_clk_lvl = 1'b0;
        gate_amp     = 0;
        lfsr_state   = LFSR_SEED;
    endfunction

    // steps the model in the active mode; random mode scales a galois shift to the step range
    function automatic void advance_step(int unsigned n);
        logic lsb;
        case (active_cfg.direction)
            DIR_FORWARD: begin
                seq_pos = (seq_pos + 1) % n;
            end
            DIR_BACKWARD: begin
                seq_pos = (seq_pos + n - 1) % n;
            end
            DIR_PENDULUM: begin
                if (n < 2) begin
                    seq_pos = 0;
                end else if (pend_up) begin
                    seq_pos++;
                    if (seq_pos >= n - 1) begin
                        seq_pos = n - 1;
                        pend_up = 1'b0;
                    end
                end else if (seq_pos <= 1) begin
                    seq_pos = 0;
                    pend_up = 1'b1;
                end else begin
                    seq_pos--;
                end
            end
            default: begin
                lsb        = lfsr_state[0];
                lfsr_state = lfsr_state >> 1;
                if (lsb) lfsr_state ^= LFSR_TAPS;
                if (lfsr_state == 16'd0) lfsr_state = LFSR_SEED;
                seq_pos = (int'(lfsr_state) * n) >> 16;
            end
        endcase
    endfunction

    function automatic t_sample_result predict_sample(logic clk_lvl, logic patched,
                                                      logic rst_lvl);
        int unsigned    n;
        int unsigned    target;
        int unsigned    raised;
        logic [32:0]    phase_sum;
        logic           window;
        t_sample_result r;
        n = active_cfg.step_count;
        if (n < 1) n = 1;
        if (n > NUM_STEPS) n = NUM_STEPS;

        if (rst_lvl && !last_rst_lvl) begin
            seq_pos   = 0;
            pend_up   = 1'b1;
            acc_phase = '0;
        end
        last_rst_lvl = rst_lvl;

        // a shrunken step count pulls the position back to the start
        if (seq_pos >= n) seq_pos = 0;

        if (patched) begin
            if (clk_lvl && !last_clk_lvl) advance_step(n);
            last_clk_lvl = clk_lvl;
            window       = clk_lvl;
        end else begin
            phase_sum = {1'b0, acc_phase} + {1'b0, active_cfg.phase_inc};
            acc_phase = phase_sum[31:0];
            if (phase_sum[32]) advance_step(n);
            window = acc_phase < active_cfg.gate_thr;
        end

        target = (window && active_cfg.gate_mask[seq_pos[3:0]]) ? GATE_FULL : GATE_SHUT;
        if (gate_amp < target) begin
            raised   = gate_amp + active_cfg.ramp_inc;
            gate_amp = (raised > target) ? target : raised;
        end else if (gate_amp > target) begin
            gate_amp = (gate_amp - target > active_cfg.ramp_inc) ?
                       gate_amp - active_cfg.ramp_inc : target;
        end

        if (seq_pos < 8) r.pitch = active_cfg.pitch_lo[5 * seq_pos +: 5];
        else             r.pitch = active_cfg.pitch_hi[5 * (seq_pos - 8) +: 5];
        r.gate = gate_amp[15:0];
        r.step = seq_pos[3:0];
        return r;
    endfunction

    // appends one prediction at the tail of the expected queue
    function automatic void queue_expected(t_sample_result r);
        expected_results = {expected_results, r};
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // writes every register in index order; only called while the block is idle
    task automatic load_settings(input t_seq_cfg s);
        t_reg_index      idx;
        logic [39:0]     data;
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 8; i++) begin
            idx = t_reg_index'(i);
            case (idx)
                REG_STEP_COUNT:      data = 40'(s.step_count);
                REG_STEP_DIRECTION:  data = 40'(s.direction);
                REG_PHASE_INCREMENT: data = 40'(s.phase_inc);
                REG_GATE_THRESHOLD:  data = 40'(s.gate_thr);
                REG_RAMP_INCREMENT:  data = 40'(s.ramp_inc);
                REG_GATE_MASK:       data = 40'(s.gate_mask);
                REG_PITCH_BANK_LOW:  data = s.pitch_lo;
                default:             data = s.pitch_hi;
            endcase
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        active_cfg  = s;
    endtask

    // valid stays high into the next item when no gap is drawn
    task automatic send_sample(input logic clk_lvl, input logic patched, input logic rst_lvl);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_clock_level   <= clk_lvl;
        i_clock_patched <= patched;
        i_reset_level   <= rst_lvl;
        do @(posedge i_clk); while (o_in_stall);
        queue_expected(predict_sample(clk_lvl, patched, rst_lvl));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // receiver: a random wait after each result while out gaps are on, or a long hold on request
    initial begin : result_stall_driver
        int wait_cycles;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (out_gaps_on && o_out_valid && !i_out_stall) begin
                wait_cycles = $urandom_range(0, 4);
                if (wait_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sample_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: pitch %0d gate %0d step %0d",
                             o_pitch_semitones, o_gate_level, o_current_step);
            end else begin
                want = expected_results.pop_front();
                if (o_pitch_semitones !== want.pitch || o_gate_level !== want.gate ||
                    o_current_step !== want.step) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch (exp/got): pitch %0d/%0d gate %0d/%0d step %0d/%0d",
                                 want.pitch, o_pitch_semitones, want.gate, o_gate_level,
                                 want.step, o_current_step);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // short hand-picked runs: every advance mode, clamped counts, reset edges,
    // one-step pendulum, pendulum turns, extreme pitches and a frozen ramp
    task automatic test_directed_cases();
        t_seq_cfg s;
        // external clock, three steps, partial gate mask, extreme pitches
        s = '{step_count: 5'd3, direction: DIR_FORWARD, phase_inc: 32'd0, gate_thr: 32'd0,
              ramp_inc: 16'hFFFF, gate_mask: 16'h0005,
              pitch_lo: {5'd2, 5'h1F, 5'd1, 5'd0, 5'd12, 5'h14, 5'd15, 5'h10},
              pitch_hi: 40'hFF_FFFF_FFFF};
        load_settings(s);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        wait_results_drained();

        // zero count clamps to one; pendulum then stays on step 0
        s = '{step_count: 5'd0, direction: DIR_PENDULUM, phase_inc: 32'hFFFF_FFFF,
              gate_thr: 32'd0, ramp_inc: 16'd1, gate_mask: 16'hFFFF,
              pitch_lo: 40'h55_AAAA_5555, pitch_hi: 40'd0};
        load_settings(s);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        wait_results_drained();

        // oversized count clamps to sixteen; backward wraps to the top step
        s = '{step_count: 5'd31, direction: DIR_BACKWARD, phase_inc: 32'h8000_0000,
              gate_thr: 32'hFFFF_FFFF, ramp_inc: 16'd1000, gate_mask: 16'hFFFF,
              pitch_lo: 40'd0, pitch_hi: {5'h10, 5'd15, 5'h14, 5'd12, 5'd3, 5'h1D, 5'd7, 5'h09}};
        load_settings(s);
        repeat (4) send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        wait_results_drained();

        // count shrinks below the playing step, then pendulum turns at both ends
        s = '{step_count: 5'd3, direction: DIR_PENDULUM, phase_inc: 32'hFFFF_FFFF,
              gate_thr: 32'h8000_0000, ramp_inc: 16'h4000, gate_mask: 16'hFFFF,
              pitch_lo: {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'h1A, 5'd11}, pitch_hi: 40'd0};
        load_settings(s);
        repeat (6) send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        wait_results_drained();

        // random order with the ramp frozen and every gate masked off
        s = '{step_count: 5'd5, direction: DIR_RANDOM, phase_inc: 32'hFFFF_FFFF,
              gate_thr: 32'hFFFF_FFFF, ramp_inc: 16'd0, gate_mask: 16'h0000,
              pitch_lo: 40'hFF_FFFF_FFFF, pitch_hi: 40'd0};
        load_settings(s);
        repeat (4) send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        wait_results_drained();
    endtask

    function automatic t_seq_cfg draw_settings();
        t_seq_cfg s;
        case ($urandom_range(0, 5))
            0:       s.step_count = 5'd0;
            1:       s.step_count = 5'd1;
            2:       s.step_count = 5'd31;
            3:       s.step_count = 5'd16;
            default: s.step_count = 5'($urandom_range(2, 16));
        endcase
        s.direction = t_direction'($urandom_range(0, 3));
        // mostly large increments so the internal clock advances often
        case ($urandom_range(0, 4))
            0:       s.phase_inc = 32'd0;
            1:       s.phase_inc = 32'hFFFF_FFFF;
            2:       s.phase_inc = $urandom();
            default: s.phase_inc = $urandom_range(32'h2000_0000, 32'hFFFF_FFFF);
        endcase
        case ($urandom_range(0, 3))
            0:       s.gate_thr = 32'd0;
            1:       s.gate_thr = 32'hFFFF_FFFF;
            default: s.gate_thr = $urandom();
        endcase
        case ($urandom_range(0, 7))
            0:       s.ramp_inc = 16'd0;
            1:       s.ramp_inc = 16'd1;
            2:       s.ramp_inc = 16'hFFFF;
            default: s.ramp_inc = 16'($urandom_range(1, 12000));
        endcase
        case ($urandom_range(0, 4))
            0:       s.gate_mask = 16'h0000;
            1:       s.gate_mask = 16'hFFFF;
            default: s.gate_mask = 16'($urandom());
        endcase
        s.pitch_lo = 40'({$urandom(), $urandom()});
        s.pitch_hi = 40'({$urandom(), $urandom()});
        return s;
    endfunction

    // patched runs with toggling clock and occasional reset pulses, mixed with
    // stretches on the internal clock
    task automatic send_random_samples(input int count);
        logic patched;
        logic clk_lvl;
        logic rst_lvl;
        patched = 1'($urandom_range(0, 1));
        clk_lvl = 1'b0;
        rst_lvl = 1'b0;
        repeat (count) begin
            if ($urandom_range(0, 15) == 0) patched = ~patched;
            if ($urandom_range(0, 1) == 1) clk_lvl = ~clk_lvl;
            rst_lvl = rst_lvl ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 24) == 0);
            send_sample(clk_lvl, patched, rst_lvl);
        end
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 9; phase++) begin
            case (phase % 3)
                0: begin
                    in_gaps_on  = 1'b1;
                    out_gaps_on = 1'b1;
                end
                1: begin
                    in_gaps_on  = 1'b0;
                    out_gaps_on = 1'b0;
                end
                default: begin
                    in_gaps_on  = 1'($urandom_range(0, 1));
                    out_gaps_on = 1'($urandom_range(0, 1));
                end
            endcase
            load_settings(draw_settings());
            send_random_samples(105);
            wait_results_drained();
        end
    endtask

    // long receiver hold while items keep coming, so the input side backs up, then a full
    // pause until every result is out, then a run with gaps on both sides
    task automatic test_backpressure();
        in_gaps_on   = 1'b0;
        out_gaps_on  = 1'b0;
        hold_cycles  = 60;
        hold_request = 1'b1;
        send_random_samples(30);
        wait_results_drained();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        send_random_samples(20);
        wait_results_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_STEP_COUNT;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_clock_level   <= 1'b0;
        i_clock_patched <= 1'b0;
        i_reset_level   <= 1'b0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_settings();
        test_backpressure();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/pgss_pkg.sv
design/pgss_step_next.sv
design/pgss_gate_ramp.sv
design/pitch_gate_step_sequencer_top.sv
sim/tb_pitch_gate_step_sequencer_top.sv
